// File: hw/rtl/fia_pkg.sv
// Shared types and constants for the fenced index allocator.
package fia_pkg;

   localparam int unsigned MAX_SLOTS = 1024;
   localparam int unsigned SLOT_W    = 10;
   localparam int unsigned CNT_W     = 11;
   localparam int unsigned FENCE_W   = 64;
   localparam logic [CNT_W-1:0] NO_SLOT  = 11'd1024;
   localparam logic [CNT_W-1:0] MAX_CNT  = 11'd1024;

   typedef enum logic [1:0] {
      KIND_ALLOC     = 2'd0,
      KIND_FREE_NOW  = 2'd1,
      KIND_FREE_LATE = 2'd2,
      KIND_COLLECT   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_DOUBLE    = 2'd2,
      STATUS_EXHAUSTED = 2'd3
   } status_type;

   localparam logic [1:0] CSR_CAPACITY   = 2'd0;
   localparam logic [1:0] CSR_BASE_INDEX = 2'd1;

   typedef struct packed {
      kind_type            kind;
      logic                is_marker;
      logic                out_of_range;
      logic [SLOT_W-1:0]   slot;
      logic [FENCE_W-1:0]  fence;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] granted_slot;
      status_type       status;
      logic [CNT_W-1:0] released;
   } rsp_type;

   typedef struct packed {
      logic             accept_en;
      logic [CNT_W-1:0] base_index;
      logic [CNT_W-1:0] eff_capacity;
   } ctl_type;

   typedef struct packed {
      logic [FENCE_W-1:0] fence;
      logic [SLOT_W-1:0]  slot;
   } wait_entry_type;

endpackage

// File: hw/rtl/fia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fia_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/fia_front.sv
// Request side: classifies incoming transactions and queues them for the engine.
module fia_front
   import fia_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_kind,
   input  logic [CNT_W-1:0]    req_slot,
   input  logic [FENCE_W-1:0]  req_fence,
   input  ctl_type             ctl,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_take
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       push_ok;

   assign req_full  = (count_ff == 2'd2) || !ctl.accept_en;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.kind         = kind_type'(req_kind);
      new_cmd.is_marker    = (req_slot == NO_SLOT);
      new_cmd.out_of_range = (req_slot < ctl.base_index) || (req_slot >= ctl.eff_capacity);
      new_cmd.slot         = req_slot[SLOT_W-1:0];
      new_cmd.fence        = req_fence;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_take) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push_ok, cmd_take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// File: hw/rtl/fia_rsp_queue.sv
// Two-entry result queue between the engine and the response port.
module fia_rsp_queue
   import fia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type head
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop_ok;

   assign full   = (count_ff == 2'd2);
   assign empty  = (count_ff == 2'd0);
   assign pop_ok = pop && !empty;
   assign head   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop_ok})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/fia_back.sv
// Allocation engine: busy map, free stack, fence-ordered wait queue and registers.
module fia_back
   import fia_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_take,
   output ctl_type          ctl,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          out_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CNT_W-1:0] csr_wdata
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MARK  = 7'b0000100,
      S_POP   = 7'b0001000,
      S_CHECK = 7'b0010000,
      S_INS   = 7'b0100000,
      S_COL   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]  bump_ff, bump_in;
   logic [CNT_W-1:0]  fc_ff, fc_in;
   logic [CNT_W-1:0]  wc_ff, wc_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SLOT_W-1:0] sweep_ff, sweep_in;
   cmd_type           cur_ff, cur_in;

   logic [CNT_W-1:0]  eff_cap;
   logic [CNT_W-1:0]  cfg_eff;
   logic [CNT_W-1:0]  cfg_base;
   logic [CNT_W-1:0]  fc_dec;
   logic [SLOT_W-1:0] base_last;

   logic                busy_we, busy_re, busy_wdata;
   logic [SLOT_W-1:0]   busy_waddr, busy_raddr;
   logic                busy_rdata;
   logic                stack_we, stack_re;
   logic [SLOT_W-1:0]   stack_waddr, stack_raddr, stack_wdata, stack_rdata;
   logic                wait_we, wait_re;
   logic [SLOT_W-1:0]   wait_waddr, wait_raddr;
   wait_entry_type      wait_wdata, wait_rdata;

   assign eff_cap   = (cap_ff > MAX_CNT) ? MAX_CNT : cap_ff;
   assign cfg_eff   = (csr_wdata > MAX_CNT) ? MAX_CNT : csr_wdata;
   assign cfg_base  = (csr_wdata > eff_cap) ? eff_cap : csr_wdata;
   assign fc_dec    = fc_ff - 11'd1;
   assign base_last = base_ff[SLOT_W-1:0] - 10'd1;

   assign ctl.accept_en    = (state_ff != S_CLEAR);
   assign ctl.base_index   = base_ff;
   assign ctl.eff_capacity = eff_cap;
   assign csr_ready        = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cap_in   = cap_ff;
      base_in  = base_ff;
      bump_in  = bump_ff;
      fc_in    = fc_ff;
      wc_in    = wc_ff;
      head_in  = head_ff;
      pos_in   = pos_ff;
      n_in     = n_ff;
      sweep_in = sweep_ff;
      cur_in   = cur_ff;
      cmd_take = 1'b0;

      busy_we     = 1'b0;
      busy_waddr  = cur_ff.slot;
      busy_wdata  = 1'b0;
      busy_re     = 1'b0;
      busy_raddr  = cmd.slot;
      stack_we    = 1'b0;
      stack_waddr = fc_ff[SLOT_W-1:0];
      stack_wdata = cur_ff.slot;
      stack_re    = 1'b0;
      stack_raddr = fc_dec[SLOT_W-1:0];
      wait_we     = 1'b0;
      wait_waddr  = head_ff + pos_ff[SLOT_W-1:0];
      wait_wdata  = wait_rdata;
      wait_re     = 1'b0;
      wait_raddr  = head_ff;

      out_push              = 1'b0;
      out_data.granted_slot = NO_SLOT;
      out_data.status       = STATUS_OK;
      out_data.released     = '0;

      case (state_ff)
         S_CLEAR: begin
            busy_we    = 1'b1;
            busy_waddr = sweep_ff;
            busy_wdata = 1'b0;
            sweep_in   = sweep_ff + 10'd1;
            if (sweep_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            busy_we    = 1'b1;
            busy_waddr = sweep_ff;
            busy_wdata = 1'b1;
            sweep_in   = sweep_ff + 10'd1;
            if (sweep_ff == base_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_CAPACITY: begin
                     cap_in = csr_wdata;
                     if (base_ff > cfg_eff) begin
                        base_in = cfg_eff;
                     end
                  end
                  CSR_BASE_INDEX: begin
                     base_in = cfg_base;
                     if (bump_ff < cfg_base) begin
                        bump_in = cfg_base;
                     end
                     if (cfg_base != '0) begin
                        sweep_in = '0;
                        state_in = S_MARK;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (cmd_valid && !out_full) begin
               cmd_take = 1'b1;
               cur_in   = cmd;
               case (cmd.kind)
                  KIND_ALLOC: begin
                     if (fc_ff != '0) begin
                        stack_re = 1'b1;
                        fc_in    = fc_dec;
                        state_in = S_POP;
                     end else if (bump_ff < eff_cap) begin
                        busy_we               = 1'b1;
                        busy_waddr            = bump_ff[SLOT_W-1:0];
                        busy_wdata            = 1'b1;
                        bump_in               = bump_ff + 11'd1;
                        out_push              = 1'b1;
                        out_data.granted_slot = bump_ff;
                     end else begin
                        out_push        = 1'b1;
                        out_data.status = STATUS_EXHAUSTED;
                     end
                  end
                  KIND_FREE_NOW, KIND_FREE_LATE: begin
                     if (cmd.is_marker) begin
                        out_push = 1'b1;
                     end else if (cmd.out_of_range) begin
                        out_push        = 1'b1;
                        out_data.status = STATUS_RANGE;
                     end else begin
                        busy_re  = 1'b1;
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     // collect: prime a read of the oldest queued entry
                     wait_re  = 1'b1;
                     wait_raddr = head_ff;
                     n_in     = '0;
                     state_in = S_COL;
                  end
               endcase
            end
         end
         S_POP: begin
            busy_we               = 1'b1;
            busy_waddr            = stack_rdata;
            busy_wdata            = 1'b1;
            out_push              = 1'b1;
            out_data.granted_slot = {1'b0, stack_rdata};
            state_in              = S_IDLE;
         end
         S_CHECK: begin
            if (!busy_rdata) begin
               out_push        = 1'b1;
               out_data.status = STATUS_DOUBLE;
               state_in        = S_IDLE;
            end else if (cur_ff.kind == KIND_FREE_NOW) begin
               out_push = 1'b1;
               state_in = S_IDLE;
               if (fc_ff == MAX_CNT) begin
                  out_data.status = STATUS_EXHAUSTED;
               end else begin
                  busy_we  = 1'b1;
                  stack_we = 1'b1;
                  fc_in    = fc_ff + 11'd1;
               end
            end else if (wc_ff == MAX_CNT) begin
               out_push        = 1'b1;
               out_data.status = STATUS_EXHAUSTED;
               state_in        = S_IDLE;
            end else begin
               // start the insertion walk from the tail of the queue
               busy_we    = 1'b1;
               pos_in     = wc_ff;
               wait_re    = 1'b1;
               wait_raddr = head_ff + wc_ff[SLOT_W-1:0] - 10'd1;
               state_in   = S_INS;
            end
         end
         S_INS: begin
            wait_we = 1'b1;
            if ((pos_ff != '0) && (wait_rdata.fence > cur_ff.fence)) begin
               // shift the later-fenced entry up one place
               wait_wdata = wait_rdata;
               wait_re    = 1'b1;
               wait_raddr = head_ff + pos_ff[SLOT_W-1:0] - 10'd2;
               pos_in     = pos_ff - 11'd1;
            end else begin
               wait_wdata.fence = cur_ff.fence;
               wait_wdata.slot  = cur_ff.slot;
               wc_in            = wc_ff + 11'd1;
               out_push         = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_COL: begin
            if ((wc_ff != '0) && (wait_rdata.fence <= cur_ff.fence) && (fc_ff != MAX_CNT)) begin
               stack_we    = 1'b1;
               stack_wdata = wait_rdata.slot;
               fc_in       = fc_ff + 11'd1;
               head_in     = head_ff + 10'd1;
               wc_in       = wc_ff - 11'd1;
               n_in        = n_ff + 11'd1;
               wait_re     = 1'b1;
               wait_raddr  = head_ff + 10'd1;
            end else begin
               out_push          = 1'b1;
               out_data.released = n_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cap_ff   <= MAX_CNT;
         base_ff  <= '0;
         bump_ff  <= '0;
         fc_ff    <= '0;
         wc_ff    <= '0;
         head_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         base_ff  <= base_in;
         bump_ff  <= bump_in;
         fc_ff    <= fc_in;
         wc_ff    <= wc_in;
         head_ff  <= head_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      n_ff   <= n_in;
      cur_ff <= cur_in;
   end

   fia_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_waddr),
      .wr_data (busy_wdata),
      .rd_en   (busy_re),
      .rd_addr (busy_raddr),
      .rd_data (busy_rdata)
   );

   fia_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (stack_re),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   fia_ram #(.WIDTH($bits(wait_entry_type)), .DEPTH(MAX_SLOTS)) u_wait_ram (
      .clock   (clock),
      .wr_en   (wait_we),
      .wr_addr (wait_waddr),
      .wr_data (wait_wdata),
      .rd_en   (wait_re),
      .rd_addr (wait_raddr),
      .rd_data (wait_rdata)
   );

endmodule

// File: hw/rtl/fenced_index_allocator_core.sv
// Top level of the fenced index allocator.
//
//  channel  direction  handshake            payload
//  req      in         push / full          req_kind, req_slot, req_fence
//  rsp      out        pop / empty          rsp_granted_slot, rsp_status, rsp_released
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Engine path per transaction: allocate from the bump pointer (idle) or the free stack
// (pop state); free via the check state (idle alone for the invalid marker or an
// out-of-range slot); deferred free via check and an insertion walk over the wait-queue
// RAM past each queued entry with a later fence; collect walks each released entry.
// A two-entry queue sits on each side of the engine; either side may stall alone.
// After reset the busy map is cleared, all 1024 slots, with full held high;
// a base_index write marks the reserved slots, one per cycle, holding csr_ready low.
module fenced_index_allocator_core
   import fia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_kind,
   input  logic [CNT_W-1:0]   req_slot,
   input  logic [FENCE_W-1:0] req_fence,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CNT_W-1:0]   rsp_granted_slot,
   output logic [1:0]         rsp_status,
   output logic [CNT_W-1:0]   rsp_released,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [CNT_W-1:0]   csr_wdata
);

   ctl_type ctl;
   logic    cmd_valid, cmd_take;
   cmd_type cmd;
   logic    out_full, out_push;
   rsp_type out_data, rsp_head;

   fia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_kind  (req_kind),
      .req_slot  (req_slot),
      .req_fence (req_fence),
      .ctl       (ctl),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   fia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .ctl       (ctl),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fia_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_granted_slot = rsp_head.granted_slot;
   assign rsp_status       = rsp_head.status;
   assign rsp_released     = rsp_head.released;

endmodule
